FILE: design/vertex_bilinear_gradient_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex bilinear gradient core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VERTEX_BILINEAR_GRADIENT_CORE_MACROS_SVH
`define VERTEX_BILINEAR_GRADIENT_CORE_MACROS_SVH

// Consequent must hold in the same cycle
`define VBG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the next cycle
`define VBG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/vbg_pkg.sv
// ----------------------------------------------------------------------------
// vbg_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package vbg_pkg;

    localparam int VBG_MAX_VERTICES = 64;
    localparam int VBG_DIV_STEPS    = 17;
    localparam int VBG_STEP_W       = 5;
    localparam int VBG_COLOR_W      = 32;
    localparam int VBG_REG_IDX_W    = 2;
    localparam int VBG_NUM_CORNERS  = 4;

    typedef enum logic [VBG_REG_IDX_W-1:0] {
        VBG_REG_TOP_LEFT     = 2'd0,
        VBG_REG_TOP_RIGHT    = 2'd1,
        VBG_REG_BOTTOM_LEFT  = 2'd2,
        VBG_REG_BOTTOM_RIGHT = 2'd3
    } vbg_reg_idx_t;

    typedef struct packed {
        logic load_en;
        logic div_init;
        logic div_step;
        logic mul_a;
        logic mul_b;
    } vbg_cmd_t;

    typedef struct packed {
        logic last_in;
        logic is_last;
        logic out_busy;
    } vbg_status_t;

endpackage

FILE: design/vbg_ram.sv
// ----------------------------------------------------------------------------
// vbg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vbg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/vbg_datapath.sv
// ----------------------------------------------------------------------------
// vbg_datapath
// Vertex store, bounding box, UQ1.16 dividers and bilinear blend.
// ----------------------------------------------------------------------------
module vbg_datapath #(
    parameter int MAX_VERTICES = vbg_pkg::VBG_MAX_VERTICES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vbg_pkg::vbg_cmd_t                   cmd,
    output vbg_pkg::vbg_status_t                status,
    input  logic                                in_accept,
    input  logic signed [15:0]                  in_x,
    input  logic signed [15:0]                  in_y,
    input  logic                                in_last,
    input  logic                                cfg_we,
    input  logic [vbg_pkg::VBG_REG_IDX_W-1:0]   cfg_addr,
    input  logic [vbg_pkg::VBG_COLOR_W-1:0]     cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [31:0]                         out_data,
    output logic                                out_last,
    output logic                                out_over
);
    import vbg_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    logic [VBG_COLOR_W-1:0] color_reg [VBG_NUM_CORNERS];
    logic [CW-1:0]          count_reg;
    logic [AW-1:0]          idx_reg;
    logic                   dropped_reg;
    logic signed [15:0]     left_reg, right_reg, top_reg_b, bottom_reg;
    logic [31:0]            rdata;
    logic                   full;
    logic                   store_we;

    logic [15:0] den_u_reg, den_v_reg, rem_u_reg, rem_v_reg;
    logic [16:0] q_u_reg, q_v_reg;
    logic [23:0] top_reg [4];
    logic [23:0] bot_reg [4];

    logic signed [16:0] w17, h17, du17, dv17;
    logic [15:0]        den_u, den_v;
    logic [32:0]        num_u, num_v;
    logic [16:0]        rem2_u, rem2_v;
    logic               ge_u, ge_v;
    logic [16:0]        nu, nv;
    logic [7:0]         chan [4];

    assign full     = (count_reg == CW'(MAX_VERTICES));
    assign store_we = in_accept && !full;

    vbg_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({in_x, in_y}),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // box extent, zero or less counts as 16
    always_comb
    begin
        w17   = {right_reg[15], right_reg} - {left_reg[15], left_reg};
        h17   = {bottom_reg[15], bottom_reg} - {top_reg_b[15], top_reg_b};
        den_u = (w17 <= 17'sd0) ? 16'd16 : w17[15:0];
        den_v = (h17 <= 17'sd0) ? 16'd16 : h17[15:0];
        du17  = {rdata[31], rdata[31:16]} - {left_reg[15], left_reg};
        dv17  = {rdata[15], rdata[15:0]} - {top_reg_b[15], top_reg_b};
        num_u = {1'b0, du17[15:0], 16'd0} + {18'd0, den_u[15:1]};
        num_v = {1'b0, dv17[15:0], 16'd0} + {18'd0, den_v[15:1]};
        rem2_u = {rem_u_reg, q_u_reg[16]};
        rem2_v = {rem_v_reg, q_v_reg[16]};
        ge_u   = (rem2_u >= {1'b0, den_u_reg});
        ge_v   = (rem2_v >= {1'b0, den_v_reg});
        nu     = ONE_Q16 - q_u_reg;
        nv     = ONE_Q16 - q_v_reg;
    end

    always_comb
    begin
        logic [40:0] acc;
        for (int c = 0; c < 4; c++)
        begin
            acc = 41'(bot_reg[c]) * 41'(q_v_reg) + 41'(top_reg[c]) * 41'(nv)
                  + 41'h0080000000;
            chan[c] = acc[39:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VBG_NUM_CORNERS; i++)
            begin
                color_reg[i] <= '0;
            end
            count_reg   <= '0;
            idx_reg     <= '0;
            dropped_reg <= 1'b0;
            left_reg    <= '0;
            right_reg   <= '0;
            top_reg_b   <= '0;
            bottom_reg  <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                color_reg[cfg_addr] <= cfg_data;
            end

            if (in_accept)
            begin
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == '0)
                    begin
                        left_reg   <= in_x;
                        right_reg  <= in_x;
                        top_reg_b  <= in_y;
                        bottom_reg <= in_y;
                    end
                    else
                    begin
                        if (in_x < left_reg)   left_reg   <= in_x;
                        if (in_x > right_reg)  right_reg  <= in_x;
                        if (in_y < top_reg_b)  top_reg_b  <= in_y;
                        if (in_y > bottom_reg) bottom_reg <= in_y;
                    end
                end
            end

            if (cmd.mul_b)
            begin
                out_valid <= 1'b1;
                if (status.is_last)
                begin
                    count_reg   <= '0;
                    dropped_reg <= 1'b0;
                    idx_reg     <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            den_u_reg <= den_u;
            den_v_reg <= den_v;
            rem_u_reg <= num_u[32:17];
            rem_v_reg <= num_v[32:17];
            q_u_reg   <= num_u[16:0];
            q_v_reg   <= num_v[16:0];
        end
        else if (cmd.div_step)
        begin
            rem_u_reg <= ge_u ? 16'(rem2_u - {1'b0, den_u_reg}) : rem2_u[15:0];
            rem_v_reg <= ge_v ? 16'(rem2_v - {1'b0, den_v_reg}) : rem2_v[15:0];
            q_u_reg   <= {q_u_reg[15:0], ge_u};
            q_v_reg   <= {q_v_reg[15:0], ge_v};
        end

        if (cmd.mul_a)
        begin
            for (int c = 0; c < 4; c++)
            begin
                top_reg[c] <= 24'(25'(color_reg[VBG_REG_TOP_RIGHT][31-8*c -: 8]) * 25'(q_u_reg)
                    + 25'(color_reg[VBG_REG_TOP_LEFT][31-8*c -: 8]) * 25'(nu));
                bot_reg[c] <= 24'(25'(color_reg[VBG_REG_BOTTOM_RIGHT][31-8*c -: 8])
                    * 25'(q_u_reg)
                    + 25'(color_reg[VBG_REG_BOTTOM_LEFT][31-8*c -: 8]) * 25'(nu));
            end
        end

        if (cmd.mul_b)
        begin
            out_data <= {chan[3], chan[2], chan[1], chan[0]};
            out_last <= status.is_last;
            out_over <= dropped_reg;
        end
    end

    assign status.last_in  = in_accept && in_last;
    assign status.is_last  = ((CW'(idx_reg) + 1'b1) == count_reg);
    assign status.out_busy = out_valid && !out_ready;

endmodule

FILE: design/vbg_ctrl.sv
// ----------------------------------------------------------------------------
// vbg_ctrl
// Sequencer: load vertices, then walk the store one vertex at a time.
// ----------------------------------------------------------------------------
module vbg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vbg_pkg::vbg_status_t status,
    output vbg_pkg::vbg_cmd_t    cmd
);
    import vbg_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD, S_READ, S_INIT, S_DIV, S_MULA, S_MULB
    } state_t;

    state_t                state_reg, state_next;
    logic [VBG_STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (status.last_in)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == VBG_STEP_W'(VBG_DIV_STEPS - 1))
                begin
                    state_next = S_MULA;
                end
            end
            S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.mul_b  = 1'b1;
                    state_next = status.is_last ? S_LOAD : S_READ;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: design/vertex_bilinear_gradient_core.sv
// Vertices are taken only in the load state; after the last vertex each stored vertex
// in turn yields one color. No input is taken while a set is being emitted.
// Per color: store read, divider setup, the two radix-2 dividers, 2 blend stages;
// the last blend stage waits while the output still holds an untaken color.
// Reset (rst_n low, asynchronous) clears the colors, box, count and flags;
// the vertex store is not cleared.
// ----------------------------------------------------------------------------
// vertex_bilinear_gradient_core
// Bilinear corner-color blend of a vertex run over its bounding box.
// ----------------------------------------------------------------------------
module vertex_bilinear_gradient_core #(
    parameter int MAX_VERTICES = vbg_pkg::VBG_MAX_VERTICES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // vertex_x, vertex_y
    input  logic                              s_tlast,  // last_vertex
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,  // red, green, blue, alpha
    output logic                              m_tlast,  // last_color
    output logic                              m_tuser,  // overflow
    input  logic                              cfg_we,
    input  logic [vbg_pkg::VBG_REG_IDX_W-1:0] cfg_addr,
    input  logic [vbg_pkg::VBG_COLOR_W-1:0]   cfg_data
);
    import vbg_pkg::*;
    `include "vertex_bilinear_gradient_core_macros.svh"

    vbg_cmd_t    cmd;
    vbg_status_t status;
    logic        in_accept;

    assign s_tready  = cmd.load_en;
    assign in_accept = s_tvalid && s_tready;

    vbg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    vbg_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_accept (in_accept),
        .in_x      (s_tdata[15:0]),
        .in_y      (s_tdata[31:16]),
        .in_last   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_over  (m_tuser)
    );

    `VBG_ASSERT_NEXT(a_last_stops_load, s_tvalid && s_tready && s_tlast, !s_tready, "load continued after last vertex")
    `VBG_ASSERT_NOW(a_no_overwrite, cmd.mul_b, !status.out_busy, "pending color overwritten")
    `VBG_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd), "conflicting datapath commands")

endmodule

FILE: test/vertex_bilinear_gradient_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_bilinear_gradient_core_tb
// Feeds vertex runs over the input stream and checks every color on the
// output stream against a local bilinear-blend predictor. Corner colors are
// rewritten between phases, and the idle and stall mix varies across phases.
// ----------------------------------------------------------------------------
module vertex_bilinear_gradient_core_tb;
    import vbg_pkg::*;

    localparam int MAXV     = VBG_MAX_VERTICES;
    localparam int HOLD_LEN = 400;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               is_last;
    } vertex_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_color;
        logic       overflow;
    } color_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // vertex_x, vertex_y
    logic        s_tlast = 1'b0;  // last_vertex
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // red, green, blue, alpha
    logic        m_tlast;         // last_color
    logic        m_tuser;         // overflow
    logic        cfg_we = 1'b0;
    logic [VBG_REG_IDX_W-1:0] cfg_addr = '0;
    logic [VBG_COLOR_W-1:0]   cfg_data = '0;

    vertex_bilinear_gradient_core u_top (.*);

    vertex_t pending_vertices[$];
    color_t  expected_colors[$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_on = 0;
    int      hold_cycles = 0;

    // Predictor state
    logic [31:0]        corner[VBG_NUM_CORNERS];
    logic signed [15:0] stored_x[MAXV];
    logic signed [15:0] stored_y[MAXV];
    int                 stored_count = 0;
    logic signed [15:0] box_l, box_t, box_r, box_b;
    bit                 dropped = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint unsigned to_unit(int pos, int lo, int size);
        int d;
        d = pos - lo;
        if (size <= 0)
            size = 16;
        if (d < 0)
            d = 0;
        return ((longint'(d) << 16) + size / 2) / size;
    endfunction

    function automatic logic [7:0] blend(int sh, longint unsigned u, longint unsigned v);
        longint unsigned tl, tr, bl, br, top, bot;
        tl = (corner[VBG_REG_TOP_LEFT] >> sh) & 8'hFF;
        tr = (corner[VBG_REG_TOP_RIGHT] >> sh) & 8'hFF;
        bl = (corner[VBG_REG_BOTTOM_LEFT] >> sh) & 8'hFF;
        br = (corner[VBG_REG_BOTTOM_RIGHT] >> sh) & 8'hFF;
        top = tr * u + tl * (65536 - u);
        bot = br * u + bl * (65536 - u);
        return 8'((bot * v + top * (65536 - v) + 64'h8000_0000) >> 32);
    endfunction

    task automatic predict_vertex_colors(vertex_t vx);
        color_t          c;
        longint unsigned u, v;
        if (stored_count < MAXV)
        begin
            if (stored_count == 0)
            begin
                box_l = vx.x; box_r = vx.x; box_t = vx.y; box_b = vx.y;
            end
            else
            begin
                if (vx.x < box_l) box_l = vx.x;
                if (vx.x > box_r) box_r = vx.x;
                if (vx.y < box_t) box_t = vx.y;
                if (vx.y > box_b) box_b = vx.y;
            end
            stored_x[stored_count] = vx.x;
            stored_y[stored_count] = vx.y;
            stored_count++;
        end
        else
            dropped = 1;
        if (vx.is_last)
        begin
            for (int i = 0; i < stored_count; i++)
            begin
                u = to_unit(stored_x[i], box_l, int'(box_r) - int'(box_l));
                v = to_unit(stored_y[i], box_t, int'(box_b) - int'(box_t));
                c.red = blend(24, u, v);
                c.green = blend(16, u, v);
                c.blue = blend(8, u, v);
                c.alpha = blend(0, u, v);
                c.last_color = (i + 1 == stored_count);
                c.overflow = dropped;
                expected_colors.insert(expected_colors.size(), c);
            end
            stored_count = 0;
            dropped = 0;
        end
    endtask

    // Driver: one request per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t vx;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                vx.x = s_tdata[15:0];
                vx.y = s_tdata[31:16];
                vx.is_last = s_tlast;
                predict_vertex_colors(vx);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    vx = pending_vertices.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {vx.y, vx.x};
                    s_tlast <= vx.is_last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_on && hold_cycles < HOLD_LEN)
            hold_cycles <= hold_cycles + 1;
    end

    // Monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        color_t c;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("unexpected color %h", m_tdata);
                    errors++;
                end
                else
                begin
                    c = expected_colors.pop_front();
                    if (m_tdata[7:0] !== c.red)
                    begin
                        $error("red exp %h got %h", c.red, m_tdata[7:0]); errors++;
                    end
                    if (m_tdata[15:8] !== c.green)
                    begin
                        $error("green exp %h got %h", c.green, m_tdata[15:8]); errors++;
                    end
                    if (m_tdata[23:16] !== c.blue)
                    begin
                        $error("blue exp %h got %h", c.blue, m_tdata[23:16]); errors++;
                    end
                    if (m_tdata[31:24] !== c.alpha)
                    begin
                        $error("alpha exp %h got %h", c.alpha, m_tdata[31:24]); errors++;
                    end
                    if (m_tlast !== c.last_color)
                    begin
                        $error("last_color exp %b got %b", c.last_color, m_tlast); errors++;
                    end
                    if (m_tuser !== c.overflow)
                    begin
                        $error("overflow exp %b got %b", c.overflow, m_tuser); errors++;
                    end
                end
            end
            m_tready <= !(hold_on && hold_cycles < HOLD_LEN)
                        && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_corner(vbg_reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        corner[idx] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_corners(logic [31:0] tl, logic [31:0] tr, logic [31:0] bl,
                               logic [31:0] br);
        write_corner(VBG_REG_TOP_LEFT, tl);
        write_corner(VBG_REG_TOP_RIGHT, tr);
        write_corner(VBG_REG_BOTTOM_LEFT, bl);
        write_corner(VBG_REG_BOTTOM_RIGHT, br);
    endtask

    task automatic push_vertex(int x, int y, bit is_last);
        vertex_t vx;
        vx.x = x;
        vx.y = y;
        vx.is_last = is_last;
        pending_vertices.insert(pending_vertices.size(), vx);
    endtask

    // Random run: full range, tight cluster or degenerate box
    task automatic push_random_set(int n);
        int kind, cx, cy;
        kind = $urandom_range(9);
        cx = $urandom_range(65535) - 32768;
        cy = $urandom_range(65535) - 32768;
        for (int i = 0; i < n; i++)
        begin
            if (kind < 5)
                push_vertex($urandom_range(65535), $urandom_range(65535), i == n - 1);
            else if (kind < 8)
                push_vertex(cx + $urandom_range(200) - 100, cy + $urandom_range(200) - 100,
                            i == n - 1);
            else if (kind == 8)
                push_vertex(cx, $urandom_range(65535), i == n - 1);
            else
                push_vertex($urandom_range(65535), cy, i == n - 1);
        end
    endtask

    task automatic push_random_phase(int items);
        int n, sent;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(19) == 0) ? MAXV + $urandom_range(4) : $urandom_range(12, 1);
            push_random_set(n);
            sent += n;
        end
    endtask

    task automatic drain();
        while (pending_vertices.size() != 0 || s_tvalid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme corners and coordinates, degenerate boxes
        set_corners(32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_FF00, 32'h00FF_00FF);
        push_vertex(0, 0, 1);
        push_vertex(-32768, -32768, 0);
        push_vertex(32767, 32767, 0);
        push_vertex(-32768, 32767, 0);
        push_vertex(32767, -32768, 0);
        push_vertex(0, 0, 1);
        push_vertex(5, 100, 0);
        push_vertex(5, -100, 0);
        push_vertex(5, 0, 1);
        push_vertex(-7, 3, 0);
        push_vertex(-7, 3, 1);
        push_vertex(0, 0, 0);
        push_vertex(1, 1, 0);
        push_vertex(2, 3, 1);
        push_vertex(16, 16, 0);
        push_vertex(-16, -16, 0);
        push_vertex(3, 9, 1);
        drain();

        set_corners(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_idle_pct = 0; recv_idle_pct = 0;
        push_random_phase(75);
        drain();

        set_corners($urandom, $urandom, $urandom, $urandom);
        send_idle_pct = 80; recv_idle_pct = 0;
        push_random_phase(75);
        drain();

        set_corners($urandom, $urandom, $urandom, $urandom);
        send_idle_pct = 0; recv_idle_pct = 80;
        push_random_phase(75);
        drain();

        set_corners(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_idle_pct = 36; recv_idle_pct = 36;
        push_random_phase(30);
        drain();

        set_corners($urandom, $urandom, $urandom, $urandom);
        send_idle_pct = 36; recv_idle_pct = 36;
        push_random_phase(75);
        drain();

        // Hold the output off while requests keep coming
        set_corners($urandom, $urandom, $urandom, $urandom);
        send_idle_pct = 0; recv_idle_pct = 20;
        hold_on = 1;
        push_random_set(6);
        push_random_set(MAXV + 2);
        push_random_phase(15);
        drain();

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/vbg_pkg.sv
design/vbg_ram.sv
design/vbg_datapath.sv
design/vbg_ctrl.sv
design/vertex_bilinear_gradient_core.sv
test/vertex_bilinear_gradient_core_tb.sv
